FILE: hw/rtl/direct_mapped_tlb_macros.svh
// Assertion macros shared by the translation buffer RTL.
`ifndef DIRECT_MAPPED_TLB_MACROS_SVH
`define DIRECT_MAPPED_TLB_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMTLB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmtlb: implication check failed");

// Next-cycle implication, checked out of reset.
`define DMTLB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmtlb: next-cycle check failed");

`endif

FILE: hw/rtl/dmtlb_pkg.sv
// Types, sizes and command codes of the translation buffer.
package dmtlb_pkg;

  localparam int ENTRIES     = 512;
  localparam int PAGE_OFS_W  = 12;
  localparam int ADDR_BITS   = 32;

  // Port fields are fixed at 32 bits; addresses beyond that are not visible.
  localparam int FIELD_W   = 32;
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int PAGE_BITS = ADDR_W - PAGE_OFS_W;
  localparam int IDX_BITS  = $clog2(ENTRIES);

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    logic  valid;
    page_t tag;
    page_t frame;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   idx;
    entry_t data;
  } wr_req_t;

  // Page number of an address already cut to ADDR_W bits.
  function automatic page_t page_of(addr_t addr);
    return addr[ADDR_W-1:PAGE_OFS_W];
  endfunction

  // Entry index: page number modulo the entry count.
  function automatic idx_t slot_of(page_t page);
    return page[IDX_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/dmtlb_store.sv
// Entry store: synchronous memory with clearing sweep and write forwarding.
`include "direct_mapped_tlb_macros.svh"

module dmtlb_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  dmtlb_pkg::idx_t   rd_idx,
  input  dmtlb_pkg::wr_req_t wr,
  output dmtlb_pkg::entry_t rd_data,
  output logic              clearing
);
  import dmtlb_pkg::*;

  entry_t mem [ENTRIES];
  entry_t q_r;
  entry_t fwd_data_r;
  logic   fwd_hit_r;
  logic   clr_act_r;
  idx_t   clr_idx_r;
  logic   clr_last;

  assign clr_last = (clr_idx_r == idx_t'(ENTRIES - 1));
  assign clearing = clr_act_r;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      clr_idx_r <= clr_idx_r + idx_t'(1);
      if (clr_last) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  // Write port: the sweep owns it while clearing
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Registered read; remember a write to the same entry on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_idx];
    end
    fwd_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= rd_en && wr.en && (wr.idx == rd_idx);
    end
  end

  // Forward the fresh write over the stale read
  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

  `DMTLB_ASSERT_IMP(a_no_wr_while_clr, clr_act_r, !wr.en && !rd_en)
  `DMTLB_ASSERT_NXT(a_clr_ends, clr_act_r && clr_last, !clr_act_r)
  `DMTLB_ASSERT_IMP(a_fwd_only_after_rd, fwd_hit_r, $past(rd_en))

endmodule

FILE: hw/rtl/direct_mapped_tlb.sv
// Top level of the direct-mapped translation buffer.
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries in_cmd (lookup, fill or invalidate), in_virt_addr and
//   in_phys_addr_in. Every request gives exactly one result, shown on the
//   out_ ports for one cycle while out_valid is high; the receiver cannot
//   hold results off, so they must be captured when they appear.
//   Pipeline: the entry is read and the request captured at the accepting
//   edge; match and write-back then go into the output register, which
//   drives the out_ ports.
//   Throughput: one request per cycle unless busy; the entry memory has one
//   read and one write port, and a write-back to the entry that the next
//   request reads is forwarded, so back-to-back requests to the same entry
//   need no stall. Reset: synchronous, active low. Counters clear at once;
//   busy stays high after reset while a sweep zeroes the entries.
//   Counts on the result ports are the totals after that request.
`include "direct_mapped_tlb_macros.svh"

module direct_mapped_tlb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dmtlb_pkg::CMD_W-1:0]   in_cmd,
  input  logic [dmtlb_pkg::FIELD_W-1:0] in_virt_addr,
  input  logic [dmtlb_pkg::FIELD_W-1:0] in_phys_addr_in,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [dmtlb_pkg::FIELD_W-1:0] out_phys_addr_out,
  output logic                          out_status,
  output logic [dmtlb_pkg::FIELD_W-1:0] out_lookup_count,
  output logic [dmtlb_pkg::FIELD_W-1:0] out_hit_count,
  output logic [dmtlb_pkg::FIELD_W-1:0] out_miss_count
);
  import dmtlb_pkg::*;

  logic    accept;
  addr_t   in_va;
  addr_t   in_pa;
  wr_req_t wr;
  entry_t  ent;

  // Execute stage registers
  logic    s1_vld_r;
  cmd_t    s1_cmd_r;
  addr_t   s1_va_r;
  page_t   s1_pa_page_r;
  logic    s1_rej_r;

  page_t   s1_page;
  logic    tag_eq;
  logic    hit_c;
  logic    status_c;
  field_t  pout_c;

  field_t  lookups_r, lookups_nxt;
  field_t  hits_r, hits_nxt;
  field_t  misses_r, misses_nxt;

  logic    out_valid_r;
  logic    out_hit_r;
  field_t  out_pa_r;
  logic    out_status_r;

  assign accept = start && !busy;
  assign in_va  = in_virt_addr[ADDR_W-1:0];
  assign in_pa  = in_phys_addr_in[ADDR_W-1:0];

  dmtlb_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_idx   (slot_of(page_of(in_va))),
    .wr       (wr),
    .rd_data  (ent),
    .clearing (busy)
  );

  // Capture the request while its entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= in_cmd;
      s1_va_r      <= in_va;
      s1_pa_page_r <= page_of(in_pa);
      s1_rej_r     <= (in_va == '0) || (in_pa == '0);
    end
  end

  // Match, decide the write-back and advance the counters
  always_comb begin
    s1_page     = page_of(s1_va_r);
    tag_eq      = (ent.tag == s1_page);
    hit_c       = 1'b0;
    status_c    = 1'b0;
    wr.en       = 1'b0;
    wr.idx      = slot_of(s1_page);
    wr.data     = ent;
    lookups_nxt = lookups_r;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    unique case (s1_cmd_r)
      CMD_LOOKUP: begin
        hit_c       = ent.valid && tag_eq;
        lookups_nxt = lookups_r + field_t'(1);
        if (ent.valid && tag_eq) begin
          hits_nxt = hits_r + field_t'(1);
        end else begin
          misses_nxt = misses_r + field_t'(1);
        end
      end
      CMD_FILL: begin
        if (s1_rej_r) begin
          status_c = 1'b1;
        end else begin
          wr.en         = 1'b1;
          wr.data.valid = 1'b1;
          wr.data.tag   = s1_page;
          wr.data.frame = s1_pa_page_r;
        end
      end
      CMD_INVAL: begin
        if (tag_eq) begin
          wr.en         = 1'b1;
          wr.data.valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // Drop everything when the stage is empty
    if (!s1_vld_r) begin
      hit_c       = 1'b0;
      status_c    = 1'b0;
      wr.en       = 1'b0;
      lookups_nxt = lookups_r;
      hits_nxt    = hits_r;
      misses_nxt  = misses_r;
    end
  end

  // Join frame and page offset, zero above the address width
  always_comb begin
    pout_c = '0;
    if (hit_c) begin
      pout_c[ADDR_W-1:0] = {ent.frame, s1_va_r[PAGE_OFS_W-1:0]};
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookups_r <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
    end else begin
      lookups_r <= lookups_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
    end
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= hit_c;
    out_pa_r     <= pout_c;
    out_status_r <= status_c;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_phys_addr_out = out_pa_r;
  assign out_status        = out_status_r;
  assign out_lookup_count  = lookups_r;
  assign out_hit_count     = hits_r;
  assign out_miss_count    = misses_r;

  `DMTLB_ASSERT_NXT(a_req_gives_result, accept, s1_vld_r)
  `DMTLB_ASSERT_IMP(a_result_from_stage, out_valid, $past(s1_vld_r))
  `DMTLB_ASSERT_IMP(a_counts_balance, 1'b1, lookups_r == field_t'(hits_r + misses_r))
  `DMTLB_ASSERT_IMP(a_hit_bumps_count, out_valid && out_hit,
                    field_t'(hits_r - $past(hits_r)) == field_t'(1))
  `DMTLB_ASSERT_IMP(a_hit_xor_status, out_valid, !(out_hit && out_status))

endmodule

FILE: verif/tlb_scoreboard_pkg.sv
// Scoreboard for the translation buffer: result prediction and comparison.
`timescale 1ns / 1ps

package tlb_scoreboard_pkg;
  import dmtlb_pkg::*;

  // Command code the block must ignore
  localparam cmd_t CMD_SPARE = 2'd3;

  typedef struct packed {
    logic   hit;
    field_t phys_addr_out;
    logic   status;
    field_t lookup_count;
    field_t hit_count;
    field_t miss_count;
  } tlb_result_t;

  class tlb_scoreboard;
    page_t       tag_mem   [ENTRIES];
    page_t       frame_mem [ENTRIES];
    bit          valid_mem [ENTRIES];
    field_t      lookups;
    field_t      hits;
    field_t      misses;
    tlb_result_t expected_q[$];
    int unsigned fail_count;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_mem[i]   = '0;
        frame_mem[i] = '0;
        valid_mem[i] = 1'b0;
      end
      lookups    = '0;
      hits       = '0;
      misses     = '0;
      fail_count = 0;
    endfunction

    // Apply one accepted request to the shadow buffer and queue its result
    function void note_request(cmd_t cmd, field_t va, field_t pa);
      page_t       page;
      idx_t        slot;
      tlb_result_t res;
      page = va[ADDR_W-1:PAGE_OFS_W];
      slot = page[IDX_BITS-1:0];
      res  = '0;
      case (cmd)
        CMD_LOOKUP: begin
          lookups++;
          if (valid_mem[slot] && tag_mem[slot] == page) begin
            hits++;
            res.hit           = 1'b1;
            res.phys_addr_out = field_t'({frame_mem[slot], va[PAGE_OFS_W-1:0]});
          end else begin
            misses++;
          end
        end
        CMD_FILL: begin
          // A zero address on either side rejects the fill outright
          if (va == '0 || pa == '0) begin
            res.status = 1'b1;
          end else begin
            tag_mem[slot]   = page;
            frame_mem[slot] = pa[ADDR_W-1:PAGE_OFS_W];
            valid_mem[slot] = 1'b1;
          end
        end
        CMD_INVAL: begin
          // Tag compared regardless of the valid bit
          if (tag_mem[slot] == page)
            valid_mem[slot] = 1'b0;
        end
        default: ;
      endcase
      res.lookup_count = lookups;
      res.hit_count    = hits;
      res.miss_count   = misses;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, field_t exp_val, field_t got_val);
      if (exp_val !== got_val) begin
        $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, got_val);
        fail_count++;
      end
    endfunction

    // Match one observed result against the oldest outstanding request
    function void check_result(tlb_result_t got);
      tlb_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result seen with no request outstanding");
        fail_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      compare_field("hit", field_t'(exp_res.hit), field_t'(got.hit));
      compare_field("phys_addr_out", exp_res.phys_addr_out, got.phys_addr_out);
      compare_field("status", field_t'(exp_res.status), field_t'(got.status));
      compare_field("lookup_count", exp_res.lookup_count, got.lookup_count);
      compare_field("hit_count", exp_res.hit_count, got.hit_count);
      compare_field("miss_count", exp_res.miss_count, got.miss_count);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

FILE: verif/tb_direct_mapped_tlb.sv
// Testbench top for the direct-mapped translation buffer.
`timescale 1ns / 1ps

module tb_direct_mapped_tlb;
  import dmtlb_pkg::*;
  import tlb_scoreboard_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_REQUESTS = 400;
  localparam int POOL_SIZE       = 24;
  localparam int HOT_SLOTS       = 6;
  localparam int DRAIN_LIMIT     = 2000;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  cmd_t   in_cmd;
  field_t in_virt_addr;
  field_t in_phys_addr_in;
  logic   out_valid;
  logic   out_hit;
  field_t out_phys_addr_out;
  logic   out_status;
  field_t out_lookup_count;
  field_t out_hit_count;
  field_t out_miss_count;

  tlb_scoreboard sb;
  page_t         page_pool[POOL_SIZE];

  direct_mapped_tlb u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_virt_addr      (in_virt_addr),
    .in_phys_addr_in   (in_phys_addr_in),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_phys_addr_out (out_phys_addr_out),
    .out_status        (out_status),
    .out_lookup_count  (out_lookup_count),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Record accepted requests, then check any result on the same edge
  always @(posedge clk) begin
    tlb_result_t got;
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0)
        sb.note_request(in_cmd, in_virt_addr, in_phys_addr_in);
      if (out_valid === 1'b1) begin
        got.hit           = out_hit;
        got.phys_addr_out = out_phys_addr_out;
        got.status        = out_status;
        got.lookup_count  = out_lookup_count;
        got.hit_count     = out_hit_count;
        got.miss_count    = out_miss_count;
        sb.check_result(got);
      end
    end
  end

  // Idle for the given gap, then hold the request until the block takes it
  task automatic issue_request(cmd_t cmd, field_t va, field_t pa, int unsigned gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_virt_addr    <= va;
    in_phys_addr_in <= pa;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Mostly addresses from a pool of pages crowded onto a few entries
  function automatic field_t pick_virt_addr();
    field_t raw;
    raw = $urandom();
    if ($urandom_range(0, 9) < 8)
      raw = field_t'({page_pool[$urandom_range(0, POOL_SIZE - 1)], raw[PAGE_OFS_W-1:0]});
    return raw;
  endfunction

  initial begin
    idx_t        hot_slot[HOT_SLOTS];
    page_t       upper;
    cmd_t        cmd;
    field_t      va;
    field_t      pa;
    int unsigned gap;
    int unsigned sel;
    int unsigned counted;
    int unsigned guard;

    sb = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_cmd          <= CMD_LOOKUP;
    in_virt_addr    <= '0;
    in_phys_addr_in <= '0;

    for (int i = 0; i < HOT_SLOTS; i++)
      hot_slot[i] = idx_t'($urandom());
    for (int i = 0; i < POOL_SIZE; i++) begin
      upper = page_t'($urandom());
      upper[IDX_BITS-1:0] = hot_slot[i % HOT_SLOTS];
      page_pool[i] = upper;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty buffer, rejected fills, extremes, eviction, spare code
    issue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0);
    issue_request(CMD_INVAL,  32'h0000_0000, 32'h0000_0000, 1);
    issue_request(CMD_FILL,   32'h0000_0000, 32'h1234_5000, 0);
    issue_request(CMD_FILL,   32'h0000_1000, 32'h0000_0000, 2);
    issue_request(CMD_FILL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    issue_request(CMD_LOOKUP, 32'hFFFF_F000, 32'h0000_0000, 3);
    issue_request(CMD_LOOKUP, 32'h001F_F123, 32'h0000_0000, 0);
    issue_request(CMD_INVAL,  32'h001F_FABC, 32'h0000_0000, 0);
    issue_request(CMD_LOOKUP, 32'hFFFF_FABC, 32'h0000_0000, 1);
    issue_request(CMD_INVAL,  32'hFFFF_F000, 32'h0000_0000, 0);
    issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    issue_request(CMD_INVAL,  32'hFFFF_F555, 32'h0000_0000, 0);
    issue_request(CMD_FILL,   32'h0000_0001, 32'h8000_0001, 4);
    issue_request(CMD_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 0);
    issue_request(CMD_FILL,   32'h0020_0000, 32'h0000_1000, 0);
    issue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0);
    issue_request(CMD_LOOKUP, 32'h0020_0ABC, 32'h0000_0000, 2);
    issue_request(CMD_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue_request(CMD_SPARE,  32'h0000_0000, 32'h0000_0000, 0);
    issue_request(CMD_FILL,   32'hAAAA_A555, 32'h5555_5AAA, 0);
    issue_request(CMD_LOOKUP, 32'hAAAA_A000, 32'h0000_0000, 0);
    issue_request(CMD_FILL,   32'h5555_5AAA, 32'hAAAA_A555, 1);
    issue_request(CMD_LOOKUP, 32'h5555_5555, 32'h0000_0000, 0);

    // Random: fills and lookups over the crowded pool, some invalidates and noise
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)
        cmd = CMD_LOOKUP;
      else if (sel < 80)
        cmd = CMD_FILL;
      else if (sel < 95)
        cmd = CMD_INVAL;
      else
        cmd = CMD_SPARE;
      va = pick_virt_addr();
      pa = $urandom();
      if (cmd == CMD_FILL && $urandom_range(0, 99) < 3)
        va = '0;
      if (cmd == CMD_FILL && $urandom_range(0, 99) < 5)
        pa = '0;
      // Alternate stretches of back-to-back requests with random gaps
      if ((counted / 40) % 3 == 0)
        gap = 0;
      else
        gap = $urandom_range(0, 13);
      issue_request(cmd, va, pa, gap);
      if (cmd != CMD_SPARE)
        counted++;
    end
    start <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);

    if (sb.pending() != 0)
      $error("%0d expected results never arrived", sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
